// File: hw/rtl/mei_pkg.sv
// ----------------------------------------------------------------------------
// mei_pkg
// Shared widths, register indexes, reset values and datapath command codes
// for the escape-time iteration engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mei_pkg;

  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int ITER_W     = 25;
  localparam int STEP_W     = 29;
  localparam int Z_W        = 32;
  localparam int WIDE_W     = 64;
  localparam int PROD_W     = COL_W + STEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_X_STEP   = 2'd1,
    CFG_Y_STEP   = 2'd2
  } cfg_idx_e;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 25'd524288;
  localparam logic [STEP_W-1:0] X_STEP_RST   = 29'd1006633;
  localparam logic [STEP_W-1:0] Y_STEP_RST   = 29'd1008313;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_COORD_MUL,
    DP_COORD_SUM,
    DP_SQUARE,
    DP_DISC,
    DP_CARD_MUL,
    DP_SET_MAX,
    DP_IT_MUL,
    DP_IT_UPD
  } dp_op_e;

  typedef struct packed {
    logic interior;
    logic escaped;
    logic limit;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mei_datapath.sv
// ----------------------------------------------------------------------------
// mei_datapath
// Coordinate mapping, interior tests and the z = z*z + c iteration registers,
// each step run on a command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module mei_datapath
  import mei_pkg::*;
#(
  parameter int FRAC_BITS   = 28,
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  wire logic              clk_i,
  input  wire dp_op_e            op_i,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [ITER_W-1:0] max_iter_i,
  input  wire logic [STEP_W-1:0] x_step_i,
  input  wire logic [STEP_W-1:0] y_step_i,
  output dp_status_t             status_o,
  output logic [ITER_W-1:0]      iterations_o,
  output logic [COL_W-1:0]       column_echo_o
);

  localparam logic signed [WIDE_W-1:0] ONE       = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] QUARTER   = ONE >>> 2;
  localparam logic signed [WIDE_W-1:0] HALF      = ONE >>> 1;
  localparam logic signed [WIDE_W-1:0] THREE_Q   = 3 * QUARTER;
  localparam logic signed [WIDE_W-1:0] C_R0      = -(ONE <<< 1);
  localparam logic signed [WIDE_W-1:0] C_I0      = -(9 * (ONE >>> 3));
  localparam logic [WIDE_W-1:0]        SIXTEENTH = 64'd1 << (2 * FRAC_BITS - 4);
  localparam logic [WIDE_W-1:0]        FOUR      = 64'd1 << (2 * FRAC_BITS + 2);
  localparam int                       COL_LIM   = MAX_COLUMNS - 1;
  localparam int                       ROW_LIM   = MAX_ROWS - 1;

  function automatic logic signed [Z_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = WIDE_W'(32'sh80000000);
    if (v > hi) begin
      return hi[Z_W-1:0];
    end else if (v < lo) begin
      return lo[Z_W-1:0];
    end
    return v[Z_W-1:0];
  endfunction

  logic [COL_W-1:0]         col_q;
  logic [ROW_W-1:0]         row_q;
  logic [PROD_W-1:0]        px_q, py_q;
  logic signed [Z_W-1:0]    cr_q, ci_q;
  logic signed [WIDE_W-1:0] x2_q, y2_q, xp2_q, a2_q;
  logic signed [32:0]       a_q;
  logic                     card_en_q;
  logic                     disc_hit_q;
  logic [31:0]              qf_q;
  logic [WIDE_W-1:0]        rhs_q;
  logic signed [WIDE_W-1:0] lhs_q;
  logic signed [Z_W-1:0]    zr_q, zi_q;
  logic signed [WIDE_W-1:0] zr2_q, zi2_q, zri_q;
  logic [ITER_W-1:0]        count_q;

  logic [COL_W-1:0]         col_eff;
  logic [ROW_W-1:0]         row_eff;
  logic [PROD_W-1:0]        px_d, py_d;
  logic signed [Z_W-1:0]    cr_d, ci_d;
  logic signed [32:0]       xp1, a_d;
  logic signed [WIDE_W-1:0] x2_d, y2_d, xp2_d, a2_d;
  logic                     card_en_d;
  logic                     disc_hit_d;
  logic [WIDE_W-1:0]        q_d;
  logic [31:0]              qf_d;
  logic [WIDE_W-1:0]        rhs_d;
  logic signed [33:0]       qs;
  logic signed [WIDE_W-1:0] lhs_d;
  logic signed [WIDE_W-1:0] zr2_d, zi2_d, zri_d;
  logic signed [WIDE_W-1:0] diff;
  logic signed [Z_W-1:0]    zr_d, zi_d;
  logic [ITER_W-1:0]        count_d;

  always_comb begin
    col_eff = (32'(col_q) >= 32'(MAX_COLUMNS)) ? COL_W'(COL_LIM) : col_q;
    row_eff = (32'(row_q) >= 32'(MAX_ROWS)) ? ROW_W'(ROW_LIM) : row_q;
    px_d    = PROD_W'(col_eff) * PROD_W'(x_step_i);
    py_d    = PROD_W'(row_eff) * PROD_W'(y_step_i);
    cr_d    = sat32($signed(WIDE_W'(px_q)) + C_R0);
    ci_d    = sat32($signed(WIDE_W'(py_q)) + C_I0);

    x2_d      = cr_q * cr_q;
    y2_d      = ci_q * ci_q;
    xp1       = 33'(cr_q) + 33'(ONE);
    xp2_d     = xp1 * xp1;
    a_d       = 33'(cr_q) - 33'(QUARTER);
    a2_d      = a_d * a_d;
    card_en_d = (WIDE_W'(cr_q) > -THREE_Q) && (WIDE_W'(cr_q) < HALF)
             && (WIDE_W'(ci_q) < ONE) && (WIDE_W'(ci_q) > -ONE);

    disc_hit_d = (($unsigned(x2_q) + $unsigned(y2_q)) < SIXTEENTH)
              || (($unsigned(xp2_q) + $unsigned(y2_q)) < SIXTEENTH);
    q_d        = $unsigned(a2_q) + $unsigned(y2_q);
    qf_d       = 32'(q_d >> FRAC_BITS);
    rhs_d      = $unsigned(y2_q) >> 2;

    qs    = $signed({2'b00, qf_q}) + 34'(a_q);
    lhs_d = $signed({2'b00, qf_q}) * qs;

    zr2_d   = zr_q * zr_q;
    zi2_d   = zi_q * zi_q;
    zri_d   = zr_q * zi_q;
    diff    = zr2_q - zi2_q;
    zr_d    = sat32((diff >>> FRAC_BITS) + WIDE_W'(cr_q));
    zi_d    = sat32((zri_q >>> (FRAC_BITS - 1)) + WIDE_W'(ci_q));
    count_d = count_q + ITER_W'(1);
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DP_LOAD: begin
        col_q   <= column_i;
        row_q   <= row_i;
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end
      DP_COORD_MUL: begin
        px_q <= px_d;
        py_q <= py_d;
      end
      DP_COORD_SUM: begin
        cr_q <= cr_d;
        ci_q <= ci_d;
      end
      DP_SQUARE: begin
        x2_q      <= x2_d;
        y2_q      <= y2_d;
        xp2_q     <= xp2_d;
        a2_q      <= a2_d;
        a_q       <= a_d;
        card_en_q <= card_en_d;
      end
      DP_DISC: begin
        disc_hit_q <= disc_hit_d;
        qf_q       <= qf_d;
        rhs_q      <= rhs_d;
      end
      DP_CARD_MUL: begin
        lhs_q <= lhs_d;
      end
      DP_SET_MAX: begin
        count_q <= max_iter_i;
      end
      DP_IT_MUL: begin
        zr2_q <= zr2_d;
        zi2_q <= zi2_d;
        zri_q <= zri_d;
      end
      DP_IT_UPD: begin
        zr_q    <= zr_d;
        zi_q    <= zi_d;
        count_q <= count_d;
      end
      default: begin
      end
    endcase
  end

  // cardioid compare only counts inside its bounding box
  assign status_o.interior = disc_hit_q || (card_en_q && (lhs_q < $signed(rhs_q)));
  assign status_o.escaped  = ($unsigned(zr2_q) + $unsigned(zi2_q)) >= FOUR;
  assign status_o.limit    = count_q >= max_iter_i;
  assign iterations_o      = count_q;
  assign column_echo_o     = col_q;

endmodule

`default_nettype wire

// File: hw/rtl/mei_ctrl.sv
// ----------------------------------------------------------------------------
// mei_ctrl
// Sequencer: steps the datapath through mapping, interior tests and the
// iteration loop (multiply step, then update step), then hands the count to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mei_ctrl
  import mei_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire dp_status_t status_i,
  input  wire logic       out_busy_i,
  output dp_op_e          op_o,
  output logic            push_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COORD_MUL,
    ST_COORD_SUM,
    ST_SQUARE,
    ST_DISC,
    ST_CARD_MUL,
    ST_DECIDE,
    ST_IT_MUL,
    ST_IT_UPD,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = DP_NOP;
    push_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          op_o    = DP_LOAD;
          state_d = ST_COORD_MUL;
        end
      end
      ST_COORD_MUL: begin
        op_o    = DP_COORD_MUL;
        state_d = ST_COORD_SUM;
      end
      ST_COORD_SUM: begin
        op_o    = DP_COORD_SUM;
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        op_o    = DP_SQUARE;
        state_d = ST_DISC;
      end
      ST_DISC: begin
        op_o    = DP_DISC;
        state_d = ST_CARD_MUL;
      end
      ST_CARD_MUL: begin
        op_o    = DP_CARD_MUL;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.interior) begin
          op_o    = DP_SET_MAX;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_IT_MUL;
        end
      end
      ST_IT_MUL: begin
        if (status_i.limit) begin
          state_d = ST_RESULT;
        end else begin
          op_o    = DP_IT_MUL;
          state_d = ST_IT_UPD;
        end
      end
      ST_IT_UPD: begin
        if (status_i.escaped) begin
          state_d = ST_RESULT;
        end else begin
          op_o    = DP_IT_UPD;
          state_d = ST_IT_MUL;
        end
      end
      ST_RESULT: begin
        if (!out_busy_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == ST_COORD_MUL))
    else $error("accepted beat did not start mapping");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !out_busy_i)
    else $error("result pushed into a full output register");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IT_UPD) |-> ($past(state_q) == ST_IT_MUL))
    else $error("update step without a multiply step");

  a_mul_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == DP_IT_MUL) |-> !status_i.limit)
    else $error("iteration started at the limit");

endmodule

`default_nettype wire

// File: hw/rtl/mandelbrot_escape_iteration.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration
// Escape-time count for one pixel, with a main cardioid and period-2 bulb
// shortcut, in signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// A pixel beat (column, row) is mapped to c = (-2 + column*x_step,
// -1.125 + row*y_step); points in the main cardioid or either quarter-radius
// disc return max_iter. Other points run z = z*z + c through one shared
// loop (multiply stage, then update stage) until they escape or reach
// max_iter. One pixel is in flight at a time; the next beat is taken while
// the previous result still waits in the output register. Write the config
// registers only when idle.
`default_nettype none

module mandelbrot_escape_iteration
  import mei_pkg::*;
#(
  parameter int FRAC_BITS   = 28,
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // [11:0] column, [23:12] row
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,   // [24:0] iterations, [36:25] column_echo
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [ITER_W-1:0] max_iter_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      x_step_q   <= X_STEP_RST;
      y_step_q   <= Y_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        CFG_X_STEP:   x_step_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_Y_STEP:   y_step_q   <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dp_op_e            op;
  dp_status_t        status;
  logic              push;
  logic              out_busy;
  logic [ITER_W-1:0] iterations;
  logic [COL_W-1:0]  column_echo;

  mei_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .status_i   (status),
    .out_busy_i (out_busy),
    .op_o       (op),
    .push_o     (push)
  );

  mei_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .op_i          (op),
    .column_i      (s_axis_tdata[COL_W-1:0]),
    .row_i         (s_axis_tdata[COL_W+ROW_W-1:COL_W]),
    .max_iter_i    (max_iter_q),
    .x_step_i      (x_step_q),
    .y_step_i      (y_step_q),
    .status_o      (status),
    .iterations_o  (iterations),
    .column_echo_o (column_echo)
  );

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  assign out_busy = m_valid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_data_q <= M_TDATA_W'({column_echo, iterations});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
